// ===== design/nsv_pkg.sv =====
// nsv_pkg: shared types, character codes and helpers for the nmea sentence validator
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none

package nsv_pkg;

  // default counter width for the sentence length
  localparam int LENGTH_BITS_DEF = 8;

  // depth of the verdict queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // shortest sentence that can pass
  localparam int MIN_LENGTH = 9;

  // configuration reset values
  localparam logic       CHECK_EN_RST = 1'b1;
  localparam logic [7:0] MAX_LEN_RST  = 8'd82;

  // configuration register indexes
  typedef enum logic {
    CFG_CHECK_EN = 1'b0,
    CFG_MAX_LEN  = 1'b1
  } cfg_index_t;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;

  // verdict codes, in priority order
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_LONG     = 3'd2,
    ERR_NODOLLAR = 3'd3,
    ERR_BADEND   = 3'd4,
    ERR_BADTYPE  = 3'd5,
    ERR_NOCOMMA  = 3'd6,
    ERR_CHECKSUM = 3'd7
  } err_code_t;

  // facts gathered by the front for one sentence, length count travels beside it
  typedef struct packed {
    logic       overflow;
    logic       start_ok;
    logic       type_ok;
    logic       comma_ok;
    logic       crlf_ok;
    logic       star_seen;
    logic [7:0] expect_sum;
    logic [7:0] xor_sum;
  } verdict_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0;
      return {1'b1, d[3:0]};
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = c - CH_UPPER_A + 8'd10;
      return {1'b1, d[3:0]};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = c - CH_LOWER_A + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage

`default_nettype wire

// ===== design/nsv_front.sv =====
// nsv_front: takes sentence bytes, keeps per-sentence state, emits one verdict record
// depends on: nsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsv_front #(
  parameter int LENGTH_BITS = nsv_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_char_in,
  input  wire logic                   in_end_of_sentence,
  input  wire logic                   q_full,
  output logic                        q_push,
  output nsv_pkg::verdict_t           q_verdict,
  output logic [LENGTH_BITS-1:0]      q_count
);
  import nsv_pkg::*;

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [7:0]             xor_r, xor_nxt;
  logic                   stop_r, stop_nxt;
  logic                   start_r, start_nxt;
  logic                   type_r, type_nxt;
  logic                   comma_r, comma_nxt;
  logic [7:0]             tail_r   [5];
  logic [7:0]             tail_nxt [5];
  logic                   accept;
  logic [4:0]             hi_dec, lo_dec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // per-byte state update
  always_comb begin
    start_nxt = start_r;
    type_nxt  = type_r;
    comma_nxt = comma_r;
    if (count_r == '0) begin
      start_nxt = (in_char_in == CH_DOLLAR);
    end else if (count_r <= LENGTH_BITS'(5)) begin
      if (in_char_in < CH_UPPER_A || in_char_in > CH_UPPER_Z) begin
        type_nxt = 1'b0;
      end
    end else if (count_r == LENGTH_BITS'(6)) begin
      comma_nxt = (in_char_in == CH_COMMA);
    end

    // running xor from byte 1 up to the first star, cr or nul
    xor_nxt  = xor_r;
    stop_nxt = stop_r;
    if (count_r != '0 && !stop_r) begin
      if (in_char_in == CH_STAR || in_char_in == CH_CR || in_char_in == CH_NUL) begin
        stop_nxt = 1'b1;
      end else begin
        xor_nxt = xor_r ^ in_char_in;
      end
    end

    // saturating length count
    ovf_nxt   = ovf_r | (count_r == COUNT_MAX);
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

    // last five bytes
    tail_nxt[0] = in_char_in;
    for (int i = 1; i < 5; i++) begin
      tail_nxt[i] = tail_r[i-1];
    end
  end

  // classify the tail of the sentence
  assign hi_dec = hex_decode(tail_nxt[3]);
  assign lo_dec = hex_decode(tail_nxt[2]);

  always_comb begin
    q_verdict.overflow  = ovf_nxt;
    q_verdict.start_ok  = start_nxt;
    q_verdict.type_ok   = type_nxt;
    q_verdict.comma_ok  = comma_nxt;
    q_verdict.crlf_ok   = (tail_nxt[1] == CH_CR) && (tail_nxt[0] == CH_LF);
    q_verdict.star_seen = (tail_nxt[4] == CH_STAR);
    q_verdict.xor_sum   = xor_nxt;
    if (!hi_dec[4]) begin
      q_verdict.expect_sum = 8'h00;
    end else if (!lo_dec[4]) begin
      q_verdict.expect_sum = {4'h0, hi_dec[3:0]};
    end else begin
      q_verdict.expect_sum = {hi_dec[3:0], lo_dec[3:0]};
    end
  end

  assign q_count = count_nxt;
  assign q_push  = accept && in_end_of_sentence;

  // sentence state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_end_of_sentence)) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      xor_r   <= 8'h00;
      stop_r  <= 1'b0;
      start_r <= 1'b0;
      type_r  <= 1'b1;
      comma_r <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        tail_r[i] <= 8'h00;
      end
    end else if (accept) begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      xor_r   <= xor_nxt;
      stop_r  <= stop_nxt;
      start_r <= start_nxt;
      type_r  <= type_nxt;
      comma_r <= comma_nxt;
      for (int i = 0; i < 5; i++) begin
        tail_r[i] <= tail_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/nsv_fifo.sv =====
// nsv_fifo: short register queue carrying verdict records from front to back
// depends on: nsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsv_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = nsv_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic [DATA_W-1:0]      pop_data
);
  import nsv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/nsv_back.sv =====
// nsv_back: turns a verdict record into an error code and holds the result register
// depends on: nsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsv_back #(
  parameter int LENGTH_BITS = nsv_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire nsv_pkg::verdict_t      q_verdict,
  input  wire logic [LENGTH_BITS-1:0] q_count,
  output logic                        q_pop,
  input  wire logic                   check_en,
  input  wire logic [7:0]             max_len,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_sentence_ok,
  output logic [2:0]                  out_error_code,
  output logic [7:0]                  out_sentence_length,
  output logic [7:0]                  out_computed_checksum
);
  import nsv_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > 8) ? LENGTH_BITS : 8;

  logic [CMP_W-1:0] cnt_ext;
  err_code_t        code;
  logic [7:0]       len_sat;
  logic             out_valid_r;
  logic             ok_r;
  logic [2:0]       code_r;
  logic [7:0]       len_r;
  logic [7:0]       sum_r;

  assign cnt_ext = CMP_W'(q_count);
  assign len_sat = (cnt_ext > CMP_W'(255)) ? 8'hFF : cnt_ext[7:0];

  // checks in priority order
  always_comb begin
    code = ERR_OK;
    if (!q_verdict.overflow && cnt_ext < CMP_W'(MIN_LENGTH)) begin
      code = ERR_SHORT;
    end else if (q_verdict.overflow || cnt_ext > CMP_W'(max_len)) begin
      code = ERR_LONG;
    end else if (!q_verdict.start_ok) begin
      code = ERR_NODOLLAR;
    end else if (!q_verdict.crlf_ok) begin
      code = ERR_BADEND;
    end else if (!q_verdict.type_ok) begin
      code = ERR_BADTYPE;
    end else if (!q_verdict.comma_ok) begin
      code = ERR_NOCOMMA;
    end else if (check_en && q_verdict.star_seen &&
                 q_verdict.expect_sum != q_verdict.xor_sum) begin
      code = ERR_CHECKSUM;
    end
  end

  // load the result register when it is empty or being taken
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ok_r   <= (code == ERR_OK);
      code_r <= code;
      len_r  <= len_sat;
      sum_r  <= q_verdict.xor_sum;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_sentence_ok       = ok_r;
  assign out_error_code        = code_r;
  assign out_sentence_length   = len_r;
  assign out_computed_checksum = sum_r;

endmodule

`default_nettype wire

// ===== design/nmea_sentence_validator.sv =====
// nmea_sentence_validator: top level, configuration registers and front/queue/back wiring
// depends on: nsv_pkg, nsv_front, nsv_fifo, nsv_back
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   in      | input     | in_valid / in_ready  | in_char_in, in_end_of_sentence
//   out     | output    | out_valid/out_ready  | out_sentence_ok, out_error_code,
//           |           |                      | out_sentence_length, out_computed_checksum
//   cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one byte is taken per cycle while in_ready is high; the front's byte update is a
// count, compare and xor; a verdict reaches out via the record queue and result register
// in_ready drops only when the two-entry verdict queue is full behind a stalled output
// cfg_ready is always high; reset is synchronous, active low, and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_validator #(
  parameter int LENGTH_BITS = nsv_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_char_in,
  input  wire logic                 in_end_of_sentence,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_sentence_ok,
  output logic [2:0]                out_error_code,
  output logic [7:0]                out_sentence_length,
  output logic [7:0]                out_computed_checksum,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire nsv_pkg::cfg_index_t  cfg_index,
  input  wire logic [7:0]           cfg_data
);
  import nsv_pkg::*;

  localparam int REC_W = $bits(verdict_t) + LENGTH_BITS;

  logic                   check_en_r;
  logic [7:0]             max_len_r;
  logic                   q_full, q_push, q_pop, q_valid;
  verdict_t               f_verdict, b_verdict;
  logic [LENGTH_BITS-1:0] f_count, b_count;
  logic [REC_W-1:0]       q_rd_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_en_r <= CHECK_EN_RST;
      max_len_r  <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHECK_EN: check_en_r <= cfg_data[0];
        CFG_MAX_LEN:  max_len_r  <= cfg_data;
      endcase
    end
  end

  // byte intake and classification
  nsv_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_in        (in_char_in),
    .in_end_of_sentence(in_end_of_sentence),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_verdict         (f_verdict),
    .q_count           (f_count)
  );

  // verdict record queue
  nsv_fifo #(
    .DATA_W(REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({f_count, f_verdict}),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_rd_data)
  );

  assign b_count   = q_rd_data[REC_W-1 -: LENGTH_BITS];
  assign b_verdict = verdict_t'(q_rd_data[$bits(verdict_t)-1:0]);

  // verdict and result register
  nsv_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_verdict            (b_verdict),
    .q_count              (b_count),
    .q_pop                (q_pop),
    .check_en             (check_en_r),
    .max_len              (max_len_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_sentence_ok      (out_sentence_ok),
    .out_error_code       (out_error_code),
    .out_sentence_length  (out_sentence_length),
    .out_computed_checksum(out_computed_checksum)
  );

endmodule

`default_nettype wire

// ===== design/nsv_checker.sv =====
// nsv_checker: port-level assertions for the nmea sentence validator, bound to the top level
// depends on: nsv_pkg, nmea_sentence_validator
`timescale 1ns / 1ps
`default_nettype none

module nsv_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic [7:0]          in_char_in,
  input wire logic                in_end_of_sentence,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                out_sentence_ok,
  input wire logic [2:0]          out_error_code,
  input wire logic [7:0]          out_sentence_length,
  input wire logic [7:0]          out_computed_checksum,
  input wire logic                cfg_valid,
  input wire logic                cfg_ready,
  input wire nsv_pkg::cfg_index_t cfg_index,
  input wire logic [7:0]          cfg_data
);
  import nsv_pkg::*;

  // no result straight after reset
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid in the cycle after reset");

  // a stalled transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_error_code) &&
      $stable(out_sentence_length) && $stable(out_computed_checksum))
    else $error("stalled result changed");

  // pass flag agrees with the error code
  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sentence_ok == (out_error_code == ERR_OK)))
    else $error("sentence_ok disagrees with error_code");

  // a short verdict carries a short length, and a passing one is long enough
  a_short_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_SHORT |-> out_sentence_length < 8'(MIN_LENGTH))
    else $error("short verdict on a long enough sentence");

  a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_ok |-> out_sentence_length >= 8'(MIN_LENGTH))
    else $error("passing sentence below minimum length");

endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (.*);

`default_nettype wire

// ===== bench/nmea_sentence_validator_test.sv =====
// nmea_sentence_validator_test: self-checking bench for the nmea sentence validator
// holds a verdict scoreboard class with its own sentence predictor, plus driving tasks
// depends on: nsv_pkg, nmea_sentence_validator
`timescale 1ns / 1ps

// one expected verdict
typedef struct {
  bit                 ok;
  nsv_pkg::err_code_t code;
  logic [7:0]         length;
  logic [7:0]         checksum;
} verdict_s;

// tracks the sentence in flight and the verdicts still owed by the block
class verdict_board;
  localparam logic [7:0] COUNT_MAX = 8'hFF;
  localparam int HEX_BASE = 16;

  verdict_s   owed_q[$];
  int         errors;
  bit         check_en;
  logic [7:0] max_len;
  logic [7:0] count;
  bit         over;
  logic [7:0] xsum;
  bit         xstop;
  bit         start_ok;
  bit         type_ok;
  bit         comma_ok;
  logic [7:0] tail [5];

  function new();
    errors   = 0;
    check_en = nsv_pkg::CHECK_EN_RST;
    max_len  = nsv_pkg::MAX_LEN_RST;
    clear_sentence();
  endfunction

  function void clear_sentence();
    count    = '0;
    over     = 1'b0;
    xsum     = '0;
    xstop    = 1'b0;
    start_ok = 1'b0;
    type_ok  = 1'b1;
    comma_ok = 1'b0;
    foreach (tail[i]) tail[i] = '0;
  endfunction

  function void set_config(nsv_pkg::cfg_index_t idx, logic [7:0] data);
    if (idx == nsv_pkg::CFG_CHECK_EN) check_en = data[0];
    else max_len = data;
  endfunction

  // digit value, or -1 for a byte outside 0-9, A-F, a-f
  function int nibble_of(logic [7:0] c);
    if (c >= nsv_pkg::CH_DIGIT_0 && c <= nsv_pkg::CH_DIGIT_9) return int'(c - nsv_pkg::CH_DIGIT_0);
    if (c >= nsv_pkg::CH_UPPER_A && c <= nsv_pkg::CH_UPPER_F) return int'(c - nsv_pkg::CH_UPPER_A) + 10;
    if (c >= nsv_pkg::CH_LOWER_A && c <= nsv_pkg::CH_LOWER_F) return int'(c - nsv_pkg::CH_LOWER_A) + 10;
    return -1;
  endfunction

  // accepted input transaction: update the sentence state, owe a verdict on the last byte
  function void note_byte(logic [7:0] c, bit last);
    int       pos;
    int       hi;
    int       lo;
    int       given;
    verdict_s v;
    pos = count;
    if (pos == 0) start_ok = (c == nsv_pkg::CH_DOLLAR);
    else if (pos <= 5) begin
      if (c < nsv_pkg::CH_UPPER_A || c > nsv_pkg::CH_UPPER_Z) type_ok = 1'b0;
    end else if (pos == 6) comma_ok = (c == nsv_pkg::CH_COMMA);

    // running xor halts at the first star, cr or nul after the first byte
    if (pos >= 1 && !xstop) begin
      if (c == nsv_pkg::CH_STAR || c == nsv_pkg::CH_CR || c == nsv_pkg::CH_NUL) xstop = 1'b1;
      else xsum ^= c;
    end

    if (count == COUNT_MAX) over = 1'b1;
    else count++;

    for (int i = 4; i > 0; i--) tail[i] = tail[i-1];
    tail[0] = c;
    if (!last) return;

    // checks in priority order
    v.code = nsv_pkg::ERR_OK;
    if (!over && count < nsv_pkg::MIN_LENGTH) v.code = nsv_pkg::ERR_SHORT;
    else if (over || count > max_len) v.code = nsv_pkg::ERR_LONG;
    else if (!start_ok) v.code = nsv_pkg::ERR_NODOLLAR;
    else if (tail[1] != nsv_pkg::CH_CR || tail[0] != nsv_pkg::CH_LF) v.code = nsv_pkg::ERR_BADEND;
    else if (!type_ok) v.code = nsv_pkg::ERR_BADTYPE;
    else if (!comma_ok) v.code = nsv_pkg::ERR_NOCOMMA;
    else if (check_en && tail[4] == nsv_pkg::CH_STAR) begin
      hi = nibble_of(tail[3]);
      lo = nibble_of(tail[2]);
      given = 0;
      if (hi >= 0) begin
        given = hi;
        if (lo >= 0) given = given * HEX_BASE + lo;
      end
      if (given[7:0] != xsum) v.code = nsv_pkg::ERR_CHECKSUM;
    end
    v.ok       = (v.code == nsv_pkg::ERR_OK);
    v.length   = count;
    v.checksum = xsum;
    owed_q.push_back(v);
    clear_sentence();
  endfunction

  // accepted result transaction: compare with the oldest owed verdict
  function void check_verdict(bit ok, logic [2:0] code, logic [7:0] length, logic [7:0] checksum);
    verdict_s v;
    if (owed_q.size() == 0) begin
      $error("verdict arrived with no sentence outstanding");
      errors++;
      return;
    end
    v = owed_q.pop_front();
    if (ok !== v.ok) begin
      $error("sentence_ok: expected %0d, got %0d", v.ok, ok);
      errors++;
    end
    if (code !== v.code) begin
      $error("error_code: expected %0d, got %0d", v.code, code);
      errors++;
    end
    if (length !== v.length) begin
      $error("sentence_length: expected %0d, got %0d", v.length, length);
      errors++;
    end
    if (checksum !== v.checksum) begin
      $error("computed_checksum: expected %0h, got %0h", v.checksum, checksum);
      errors++;
    end
  endfunction

  function int outstanding();
    return owed_q.size();
  endfunction
endclass

module nmea_sentence_validator_test;
  import nsv_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_in = '0;
  logic       in_end_of_sentence = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_sentence_ok;
  logic [2:0] out_error_code;
  logic [7:0] out_sentence_length;
  logic [7:0] out_computed_checksum;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_CHECK_EN;
  logic [7:0] cfg_data = '0;

  verdict_board board;
  logic [7:0]   frame_q[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  nmea_sentence_validator u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_char_in            (in_char_in),
    .in_end_of_sentence    (in_end_of_sentence),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_sentence_ok       (out_sentence_ok),
    .out_error_code        (out_error_code),
    .out_sentence_length   (out_sentence_length),
    .out_computed_checksum (out_computed_checksum),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #6 clk = ~clk;

  // result side: check accepted transactions, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_verdict(out_sentence_ok, out_error_code, out_sentence_length,
                          out_computed_checksum);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transaction; valid stays high for a back-to-back follower
  task automatic send_byte(input logic [7:0] c, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_char_in         <= c;
    in_end_of_sentence <= last;
    do @(posedge clk); while (!in_ready);
    board.note_byte(c, last);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  // one configuration transaction; the caller drops cfg_valid after the last one
  task automatic write_cfg(input cfg_index_t idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_config(idx, data);
  endtask

  // drain owed verdicts, then let the pipeline settle
  task automatic wait_drained();
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] body_char();
    int r;
    r = $urandom_range(99);
    if (r < 90) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 94) return CH_STAR;
    if (r < 97) return CH_NUL;
    return CH_CR;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return CH_DIGIT_0 + 8'(n);
    return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    if ($urandom_range(1)) return 8'($urandom_range(CH_UPPER_F + 1, CH_UPPER_Z));
    return 8'($urandom_range(CH_LOWER_F + 1, 8'h7A));
  endfunction

  // mostly well-formed sentences with random content, some broken, some noise
  task automatic build_frame();
    int         kind;
    int         body_len;
    int         pick;
    int         n;
    bit         stopped;
    logic [7:0] sum;
    logic [7:0] v;
    frame_q.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(1, 20);
      repeat (n) frame_q.push_back(8'($urandom_range(255)));
      return;
    end
    frame_q.push_back(CH_DOLLAR);
    repeat (5) frame_q.push_back(CH_UPPER_A + 8'($urandom_range(25)));
    frame_q.push_back(CH_COMMA);
    body_len = ($urandom_range(9) == 0) ? $urandom_range(55, 80) : $urandom_range(0, 20);
    repeat (body_len) frame_q.push_back(body_char());

    // optional trailing checksum: right, wrong, or with a non-hex digit
    if ($urandom_range(3) != 0) begin
      sum = '0;
      stopped = 1'b0;
      for (int i = 1; i < frame_q.size() && !stopped; i++) begin
        if (frame_q[i] == CH_STAR || frame_q[i] == CH_CR || frame_q[i] == CH_NUL) stopped = 1'b1;
        else sum ^= frame_q[i];
      end
      pick = $urandom_range(9);
      v = (pick < 7) ? sum : 8'($urandom_range(255));
      frame_q.push_back(CH_STAR);
      frame_q.push_back(pick == 8 ? non_hex_char() : hex_char(v[7:4]));
      frame_q.push_back(pick == 9 ? non_hex_char() : hex_char(v[3:0]));
    end
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);

    // break one part of the sentence
    if (kind < 30) begin
      case ($urandom_range(4))
        0: frame_q[0] = 8'($urandom_range(255));
        1: frame_q[$urandom_range(1, 5)] = 8'($urandom_range(255));
        2: frame_q[6] = 8'($urandom_range(255));
        3: frame_q[frame_q.size() - 1 - $urandom_range(1)] = 8'($urandom_range(255));
        default: begin
          n = $urandom_range(1, frame_q.size() - 1);
          repeat (n) void'(frame_q.pop_back());
        end
      endcase
    end
  endtask

  // well-formed sentence of a given total length
  task automatic build_long(input int len);
    frame_q.delete();
    push_text("$GPLNG,");
    while (frame_q.size() < len - 2) frame_q.push_back(8'($urandom_range(8'h2D, 8'h7E)));
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
  endtask

  task automatic run_phase(input bit en, input logic [7:0] mlen, input int idle_pct,
                           input int stall_pct, input bit with_long);
    int bytes_sent;
    int frames_sent;
    wait_drained();
    write_cfg(CFG_CHECK_EN, {7'b0, en});
    write_cfg(CFG_MAX_LEN, mlen);
    cfg_valid <= 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    bytes_sent  = 0;
    frames_sent = 0;
    // full counter and one past it
    if (with_long) begin
      build_long(255);
      send_frame();
      build_long(256);
      send_frame();
    end
    while (bytes_sent < 130 || frames_sent < 4) begin
      build_frame();
      send_frame();
      bytes_sent += frame_q.size();
      frames_sent++;
    end
    in_valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lone top byte, minimal sentence, lowercase checksum, lone nul
    frame_q.delete();
    frame_q.push_back(8'hFF);
    send_frame();
    frame_q.delete();
    push_text("$ABCDE,\r\n");
    send_frame();
    frame_q.delete();
    push_text("$ABCDE,*6d\r\n");
    send_frame();
    frame_q.delete();
    frame_q.push_back(CH_NUL);
    send_frame();
    in_valid <= 1'b0;

    run_phase(1'b1, 8'd82, 0, 0, 1'b0);
    run_phase(1'b1, 8'd255, 71, 0, 1'b1);
    run_phase(1'b0, 8'd82, 0, 71, 1'b0);
    run_phase(1'b1, 8'd9, 24, 24, 1'b0);
    run_phase(1'b1, 8'($urandom_range(9, 255)), 0, 0, 1'b0);
    run_phase(1'b0, 8'd255, 24, 24, 1'b0);

    recv_stall_pct = 0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("nmea_sentence_validator verification clean");
    end else begin
      $display("nmea_sentence_validator verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("nmea_sentence_validator verification failed");
    $finish;
  end

endmodule

// ===== nmea_sentence_validator.f =====
design/nsv_pkg.sv
design/nsv_front.sv
design/nsv_fifo.sv
design/nsv_back.sv
design/nmea_sentence_validator.sv
design/nsv_checker.sv
bench/nmea_sentence_validator_test.sv
